// ===== src/svf_pkg.sv =====
// Shared definitions for the multichannel state-variable filter.
// Holds widths, register indexes, mode codes, sequencer states and the control struct.
// No dependencies.
package svf_pkg;

  // Field and format widths
  localparam int CHAN_BITS        = 3;
  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int GUARD_BITS       = 8;   // extra integer bits of a filter value
  localparam int COEF_FRAC        = 16;
  localparam int FREQ_BITS        = 15;
  localparam int DAMP_BITS        = 18;
  localparam int COEF_BITS        = 18;  // widest coefficient
  localparam int MODE_BITS        = 3;

  // Configuration port
  localparam int CFG_DATA_BITS = 18;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_FREQ = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DAMP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 2'd2;

  localparam logic [FREQ_BITS-1:0] FREQ_RESET = 15'd6283;
  localparam logic [DAMP_BITS-1:0] DAMP_RESET = 18'd85000;

  // Filter mode codes; the remaining codes give a zero result
  localparam logic [MODE_BITS-1:0] MODE_LOW   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_HIGH  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_BAND  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_NOTCH = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_PEAK  = 3'd4;

  // Sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_FB,
    ST_LOW,
    ST_NOTCH,
    ST_HIGH,
    ST_MUL_FH,
    ST_BAND,
    ST_SEL,
    ST_OUT
  } seq_state_t;

  // Destination of the shared add and saturate step
  typedef enum logic [1:0] {
    DST_LOW,
    DST_NOTCH,
    DST_HIGH,
    DST_BAND
  } dst_t;

  typedef enum logic {
    COEF_FREQ,
    COEF_DAMP
  } coef_sel_t;

  typedef enum logic {
    VAL_BAND,
    VAL_HIGH
  } val_sel_t;

  // Control word from the sequencer to the datapath
  typedef struct packed {
    logic      load;
    logic      mul_en;
    coef_sel_t mul_coef;
    val_sel_t  mul_val;
    logic      add_en;
    dst_t      add_dst;
    logic      sel_en;
    logic      out_en;
  } ctrl_t;

endpackage

// ===== src/svf_state_mem.sv =====
// Per-channel filter state memory: one row of lowpass and bandpass values per channel.
// Registered read; rows never written since reset read as zero. Depends on svf_pkg.
module svf_state_mem
  import svf_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int WIDTH        = 2 * (DEF_SAMPLE_BITS + GUARD_BITS),
  localparam int IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0]        mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] row_valid;
  logic [WIDTH-1:0]        rd_data_r;
  logic                    rd_valid_r;

  // Storage array, written and read in a clocked block
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Written marks, cleared at reset so every channel starts from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= (int'(rd_addr) < NUM_CHANNELS) ? row_valid[rd_addr] : 1'b0;
      end
    end
  end

  // A row that has not been written since reset reads as zero
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== src/svf_datapath.sv =====
// Shared multiply and add-saturate unit with the working filter registers.
// Driven step by step by the control word of svf_seq. Depends on svf_pkg.
module svf_datapath
  import svf_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int SB         = SAMPLE_BITS + GUARD_BITS
) (
  input  logic                          clk,
  input  ctrl_t                         ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [FREQ_BITS-1:0]   freq_coef,
  input  logic        [DAMP_BITS-1:0]   damp_coef,
  input  logic        [MODE_BITS-1:0]   mode,
  input  logic signed [SB-1:0]          mem_low,
  input  logic signed [SB-1:0]          mem_band,
  output logic signed [SB-1:0]          low,
  output logic signed [SB-1:0]          band,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PW = SB + COEF_BITS + 1;   // full product
  localparam int RW = PW - COEF_FRAC;       // rounded product
  localparam int SW = RW + 1;               // adder result
  localparam int HW = SB + 2;               // halving adder

  localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (COEF_FRAC - 1);
  localparam logic signed [SW-1:0] S_MAX = {{(SW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {{(SW - SB + 1){1'b1}}, {(SB - 1){1'b0}}};
  localparam logic signed [SB-1:0] V_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] V_MIN = {1'b1, {(SB - 1){1'b0}}};
  localparam logic signed [SB:0] H_MAX = {{(SB - SAMPLE_BITS + 2){1'b0}},
                                          {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SB:0] H_MIN = {{(SB - SAMPLE_BITS + 2){1'b1}},
                                          {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [SB-1:0]    low_r, band_r, notch_r, high_r;
  logic signed [RW-1:0]    prod_r;
  logic signed [SB:0]      sel_r;
  logic        [COEF_BITS-1:0] coef_op;
  logic signed [SB-1:0]    val_op;
  logic signed [PW-1:0]    prod_full;
  logic signed [PW-1:0]    prod_rnd;
  logic signed [SB-1:0]    add_a;
  logic signed [RW-1:0]    add_b;
  logic                    add_sub;
  logic signed [SW-1:0]    sum;
  logic signed [SB-1:0]    sum_sat;
  logic signed [HW-1:0]    half_sum;
  logic signed [SB:0]      half_val;

  // Multiplier operands and product, rounded half up to the value's scale
  always_comb begin
    coef_op   = (ctrl.mul_coef == COEF_FREQ) ? COEF_BITS'(freq_coef) : COEF_BITS'(damp_coef);
    val_op    = (ctrl.mul_val == VAL_HIGH) ? high_r : band_r;
    prod_full = $signed({1'b0, coef_op}) * val_op;
    prod_rnd  = prod_full + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_rnd[PW-1:COEF_FRAC];
    end
  end

  // Adder operands follow from the destination register
  always_comb begin
    case (ctrl.add_dst)
      DST_LOW: begin
        add_a   = low_r;
        add_b   = prod_r;
        add_sub = 1'b0;
      end
      DST_NOTCH: begin
        add_a   = SB'(sample);
        add_b   = prod_r;
        add_sub = 1'b1;
      end
      DST_HIGH: begin
        add_a   = notch_r;
        add_b   = RW'(low_r);
        add_sub = 1'b1;
      end
      DST_BAND: begin
        add_a   = band_r;
        add_b   = prod_r;
        add_sub = 1'b0;
      end
      default: begin
        add_a   = low_r;
        add_b   = prod_r;
        add_sub = 1'b0;
      end
    endcase
    sum = add_sub ? (SW'(add_a) - SW'(add_b)) : (SW'(add_a) + SW'(add_b));
    if (sum > S_MAX) begin
      sum_sat = V_MAX;
    end else if (sum < S_MIN) begin
      sum_sat = V_MIN;
    end else begin
      sum_sat = sum[SB-1:0];
    end
  end

  // Working registers: loaded from memory, then updated one step at a time
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      low_r  <= mem_low;
      band_r <= mem_band;
    end else if (ctrl.add_en) begin
      case (ctrl.add_dst)
        DST_LOW:   low_r   <= sum_sat;
        DST_NOTCH: notch_r <= sum_sat;
        DST_HIGH:  high_r  <= sum_sat;
        DST_BAND:  band_r  <= sum_sat;
        default:   low_r   <= sum_sat;
      endcase
    end
  end

  // Pick the value for the chosen mode; peak mode is the unsaturated difference
  always_ff @(posedge clk) begin
    if (ctrl.sel_en) begin
      case (mode)
        MODE_LOW:   sel_r <= (SB + 1)'(low_r);
        MODE_HIGH:  sel_r <= (SB + 1)'(high_r);
        MODE_BAND:  sel_r <= (SB + 1)'(band_r);
        MODE_NOTCH: sel_r <= (SB + 1)'(notch_r);
        MODE_PEAK:  sel_r <= (SB + 1)'(low_r) - (SB + 1)'(high_r);
        default:    sel_r <= '0;
      endcase
    end
  end

  // Halve with rounding half up, then saturate to the sample width
  always_comb begin
    half_sum = HW'(sel_r) + HW'(1);
    half_val = half_sum[HW-1:1];
    if (half_val > H_MAX) begin
      result = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else if (half_val < H_MIN) begin
      result = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      result = half_val[SAMPLE_BITS-1:0];
    end
  end

  assign low  = low_r;
  assign band = band_r;

endmodule

// ===== src/svf_seq.sv =====
// Step sequencer for the shared filter unit: two filter iterations per item.
// Issues one control word per cycle to svf_datapath. Depends on svf_pkg.
module svf_seq
  import svf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_free,
  output ctrl_t ctrl,
  output logic  busy
);

  seq_state_t state, state_next;
  logic       iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= 1'b0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  // Next step and iteration count
  always_comb begin
    state_next = state;
    iter_next  = iter;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_MUL_FB;
        iter_next  = 1'b0;
      end
      ST_MUL_FB: state_next = ST_LOW;
      ST_LOW:    state_next = ST_NOTCH;
      ST_NOTCH:  state_next = ST_HIGH;
      ST_HIGH:   state_next = ST_MUL_FH;
      ST_MUL_FH: state_next = ST_BAND;
      ST_BAND: begin
        if (iter) begin
          state_next = ST_SEL;
        end else begin
          state_next = ST_MUL_FB;
          iter_next  = 1'b1;
        end
      end
      ST_SEL: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control word for each step
  always_comb begin
    ctrl          = '0;
    ctrl.mul_coef = COEF_FREQ;
    ctrl.mul_val  = VAL_BAND;
    ctrl.add_dst  = DST_LOW;
    case (state)
      ST_LOAD: ctrl.load = 1'b1;
      ST_MUL_FB: begin
        ctrl.mul_en = 1'b1;
      end
      ST_LOW: begin
        ctrl.add_en   = 1'b1;
        ctrl.add_dst  = DST_LOW;
        ctrl.mul_en   = 1'b1;
        ctrl.mul_coef = COEF_DAMP;
      end
      ST_NOTCH: begin
        ctrl.add_en  = 1'b1;
        ctrl.add_dst = DST_NOTCH;
      end
      ST_HIGH: begin
        ctrl.add_en  = 1'b1;
        ctrl.add_dst = DST_HIGH;
      end
      ST_MUL_FH: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_val = VAL_HIGH;
      end
      ST_BAND: begin
        ctrl.add_en  = 1'b1;
        ctrl.add_dst = DST_BAND;
      end
      ST_SEL: ctrl.sel_en = 1'b1;
      ST_OUT: ctrl.out_en = out_free;
      default: ctrl.load = 1'b0;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== src/state_variable_filter_multichannel.sv =====
// Multichannel double-sampled state-variable filter. Each item takes six steps per filter
// iteration through the one shared multiplier and saturating adder, two iterations per item,
// plus load, selection and output steps; no new item is taken until the result of the last
// one has gone into the output register, so a stalled output holds back the input as well.
// Reset (synchronous) clears all channel state to zero, sets the coefficients to their
// defaults and the mode to lowpass, and empties the output register.
module state_variable_filter_multichannel
  import svf_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  localparam int TDATA_W     = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input items
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [TDATA_W-1:0]       s_axis_tdata,   // chan_index, sample_in, zero fill
  // Result items
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [TDATA_W-1:0]       m_axis_tdata,   // chan_out, sample_out, zero fill
  // Register writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS + GUARD_BITS;
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [FREQ_BITS-1:0] freq_coef;
  logic [DAMP_BITS-1:0] damp_coef;
  logic [MODE_BITS-1:0] filter_mode;

  logic                          in_acc;
  logic [CHAN_BITS-1:0]          in_chan;
  logic [CHAN_BITS-1:0]          chan_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          chan_ok_r;
  logic                          busy;
  logic                          out_free;
  ctrl_t                         ctrl;

  logic [2*SB-1:0]               mem_rd_data;
  logic signed [SB-1:0]          dp_low, dp_band;
  logic signed [SAMPLE_BITS-1:0] dp_result;
  logic [CHAN_BITS-1:0]          out_chan;
  logic [SAMPLE_BITS-1:0]        out_sample;

  // Configuration registers; writes to indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_coef   <= FREQ_RESET;
      damp_coef   <= DAMP_RESET;
      filter_mode <= MODE_LOW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ: freq_coef   <= cfg_data[FREQ_BITS-1:0];
        REG_DAMP: damp_coef   <= cfg_data[DAMP_BITS-1:0];
        REG_MODE: filter_mode <= cfg_data[MODE_BITS-1:0];
        default:  ;
      endcase
    end
  end

  // Input item capture
  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_chan       = s_axis_tdata[CHAN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r    <= in_chan;
      sample_r  <= s_axis_tdata[CHAN_BITS +: SAMPLE_BITS];
      chan_ok_r <= (int'(in_chan) < NUM_CHANNELS);
    end
  end

  // Channel state memory, read as the item is accepted and written back at the end
  svf_state_mem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WIDTH        (2 * SB)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (IDX_W'(in_chan)),
    .wr_en   (ctrl.out_en && chan_ok_r),
    .wr_addr (IDX_W'(chan_r)),
    .wr_data ({dp_low, dp_band}),
    .rd_data (mem_rd_data)
  );

  svf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  svf_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .sample    (sample_r),
    .freq_coef (freq_coef),
    .damp_coef (damp_coef),
    .mode      (filter_mode),
    .mem_low   (mem_rd_data[2*SB-1:SB]),
    .mem_band  (mem_rd_data[SB-1:0]),
    .low       (dp_low),
    .band      (dp_band),
    .result    (dp_result)
  );

  // Output register; a channel out of range gives a zero sample
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.out_en) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      out_chan   <= chan_r;
      out_sample <= chan_ok_r ? dp_result : '0;
    end
  end

  assign m_axis_tdata = TDATA_W'({out_sample, out_chan});

  // A result appears only from the sequencer's output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(ctrl.out_en))
    else $error("result item offered without an output step");

  // The result carries the channel of the item being worked on
  a_out_chan: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_en |=> (m_axis_tdata[CHAN_BITS-1:0] == $past(chan_r)))
    else $error("result channel differs from the accepted channel");

  // A channel beyond the configured count yields a zero sample
  a_bad_chan_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_en && !chan_ok_r) |=> (out_sample == '0))
    else $error("out of range channel gave a non-zero sample");

  // No second item is taken while one is in the shared unit
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("input accepted while the filter unit is busy");

endmodule
